// ----- hdl/rsst_pkg.sv -----
package rsst_pkg;

	// Table depth and the widths that follow from it.
	localparam int MAX_ENTRIES = 16;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	// Fixed field widths of the stream words.
	localparam int MODE_W  = 2;
	localparam int BSSID_W = 48;
	localparam int RSSI_W  = 8;
	localparam int CHAN_W  = 8;
	localparam int AUTH_W  = 4;
	localparam int RIDX_W  = 4;
	localparam int STAT_W  = 3;
	localparam int ECNT_W  = 5;
	localparam int CMP_W   = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

	localparam logic [MODE_W-1:0] MODE_OFFER = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED     = 3'd0,
		ST_DUP_REPLACED = 3'd1,
		ST_DUP_DROPPED  = 3'd2,
		ST_EVICTED      = 3'd3,
		ST_DROPPED_FULL = 3'd4,
		ST_READ         = 3'd5,
		ST_CLEARED      = 3'd6
	} status_t;

	// Address source for the single table read port.
	typedef enum logic [2:0] {
		RS_PTR,
		RS_PTR_P1,
		RS_PTR_M1,
		RS_LAST,
		RS_IDX
	} rsel_t;

	typedef struct packed {
		logic [BSSID_W-1:0] bssid;
		logic               is_current;
		logic [AUTH_W-1:0]  auth;
		logic [CHAN_W-1:0]  channel;
		logic [RSSI_W-1:0]  rssi;
	} entry_t;

	typedef struct packed {
		entry_t            ent;
		logic [RIDX_W-1:0] read_index;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [ECNT_W-1:0]  entry_count;
		logic               read_valid;
		entry_t             ent;
	} result_t;

	// Controller to datapath.
	typedef struct packed {
		logic    load;
		rsel_t   rsel;
		logic    ptr_inc;
		logic    ptr_dec;
		logic    ptr_count;
		logic    ptr_last;
		logic    wr_shift;
		logic    wr_new;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    cnt_clr;
		logic    set_dup;
		logic    st_load;
		status_t st_code;
		logic    rd_capture;
		logic    out_load;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic ptr_at_count;
		logic next_below;
		logic ptr_zero;
		logic full;
		logic key_match;
		logic new_le;
		logic dup;
	} sts_t;

endpackage

// ----- hdl/rsst_dp.sv -----
module rsst_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  rsst_pkg::cmd_t  cmd,
	input  rsst_pkg::item_t item,
	output rsst_pkg::sts_t  sts,
	output rsst_pkg::result_t res
);
	import rsst_pkg::*;

	entry_t           store_q [MAX_ENTRIES];
	item_t            item_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             dup_q;
	status_t          status_q;
	logic             rd_valid_q;
	entry_t           rd_entry_q;
	result_t          res_q;

	logic [CNT_W-1:0] ptr_p1;
	logic [CNT_W-1:0] rd_addr;
	entry_t           rd_ent;
	logic             idx_hit;

	assign ptr_p1  = ptr_q + CNT_W'(1);
	assign idx_hit = CMP_W'(item_q.read_index) < CMP_W'(count_q);

	always_comb begin
		unique case (cmd.rsel)
			RS_PTR:    rd_addr = ptr_q;
			RS_PTR_P1: rd_addr = ptr_p1;
			RS_PTR_M1: rd_addr = ptr_q - CNT_W'(1);
			RS_LAST:   rd_addr = CNT_W'(MAX_ENTRIES - 1);
			RS_IDX:    rd_addr = CNT_W'(item_q.read_index);
			default:   rd_addr = ptr_q;
		endcase
	end

	assign rd_ent = store_q[rd_addr[IDX_W-1:0]];

	assign sts.ptr_at_count = (ptr_q == count_q);
	assign sts.next_below   = (ptr_p1 < count_q);
	assign sts.ptr_zero     = (ptr_q == '0);
	assign sts.full         = (count_q == CNT_W'(MAX_ENTRIES));
	assign sts.key_match    = (rd_ent.bssid == item_q.ent.bssid);
	assign sts.new_le       = ($signed(item_q.ent.rssi) <= $signed(rd_ent.rssi));
	assign sts.dup          = dup_q;

	// Table storage: at most one write per cycle, at the pointer.
	always_ff @(posedge clk) begin
		if (cmd.wr_shift) begin
			store_q[ptr_q[IDX_W-1:0]] <= rd_ent;
		end else if (cmd.wr_new) begin
			store_q[ptr_q[IDX_W-1:0]] <= item_q.ent;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.st_load) begin
			status_q <= cmd.st_code;
		end
		if (cmd.rd_capture) begin
			rd_entry_q <= rd_ent;
		end
		if (cmd.out_load) begin
			res_q.status      <= status_q;
			res_q.entry_count <= ECNT_W'(count_q);
			res_q.read_valid  <= rd_valid_q;
			res_q.ent         <= rd_valid_q ? rd_entry_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			count_q    <= '0;
			dup_q      <= 1'b0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				ptr_q      <= '0;
				dup_q      <= 1'b0;
				rd_valid_q <= 1'b0;
			end else begin
				priority if (cmd.ptr_inc) begin
					ptr_q <= ptr_p1;
				end else if (cmd.ptr_dec) begin
					ptr_q <= ptr_q - CNT_W'(1);
				end else if (cmd.ptr_count) begin
					ptr_q <= count_q;
				end else if (cmd.ptr_last) begin
					ptr_q <= CNT_W'(MAX_ENTRIES - 1);
				end else begin
					ptr_q <= ptr_q;
				end
				if (cmd.set_dup) begin
					dup_q <= 1'b1;
				end
				if (cmd.rd_capture) begin
					rd_valid_q <= idx_hit;
				end
			end
			priority if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end else begin
				count_q <= count_q;
			end
		end
	end

	assign res = res_q;

endmodule

// ----- hdl/rsst_ctrl.sv -----
module rsst_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [rsst_pkg::MODE_W-1:0]   in_mode,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  rsst_pkg::sts_t                sts,
	output rsst_pkg::cmd_t                cmd
);
	import rsst_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_SEARCH  = 8'b0000_0010,
		S_REMOVE  = 8'b0000_0100,
		S_INS_CHK = 8'b0000_1000,
		S_PLACE   = 8'b0001_0000,
		S_READ    = 8'b0010_0000,
		S_CLEAR   = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.rsel    = RS_PTR;
		cmd.st_code = ST_INSERTED;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					priority if (in_mode == MODE_OFFER) begin
						state_d = S_SEARCH;
					end else if (in_mode == MODE_CLEAR) begin
						state_d = S_CLEAR;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_SEARCH: begin
				cmd.rsel = RS_PTR;
				priority if (sts.ptr_at_count) begin
					state_d = S_INS_CHK;
				end else if (sts.key_match && sts.new_le) begin
					cmd.st_load = 1'b1;
					cmd.st_code = ST_DUP_DROPPED;
					state_d     = S_DONE;
				end else if (sts.key_match) begin
					cmd.set_dup = 1'b1;
					state_d     = S_REMOVE;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			S_REMOVE: begin
				cmd.rsel = RS_PTR_P1;
				if (sts.next_below) begin
					cmd.wr_shift = 1'b1;
					cmd.ptr_inc  = 1'b1;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_INS_CHK;
				end
			end
			S_INS_CHK: begin
				cmd.rsel    = RS_LAST;
				cmd.st_load = 1'b1;
				priority if (!sts.full) begin
					cmd.ptr_count = 1'b1;
					cmd.st_code   = sts.dup ? ST_DUP_REPLACED : ST_INSERTED;
					state_d       = S_PLACE;
				end else if (!sts.new_le) begin
					cmd.ptr_last = 1'b1;
					cmd.st_code  = ST_EVICTED;
					state_d      = S_PLACE;
				end else begin
					cmd.st_code = ST_DROPPED_FULL;
					state_d     = S_DONE;
				end
			end
			S_PLACE: begin
				cmd.rsel = RS_PTR_M1;
				if (!sts.ptr_zero && !sts.new_le) begin
					cmd.wr_shift = 1'b1;
					cmd.ptr_dec  = 1'b1;
				end else begin
					cmd.wr_new  = 1'b1;
					cmd.cnt_inc = !sts.full;
					state_d     = S_DONE;
				end
			end
			S_READ: begin
				cmd.rsel       = RS_IDX;
				cmd.rd_capture = 1'b1;
				cmd.st_load    = 1'b1;
				cmd.st_code    = ST_READ;
				state_d        = S_DONE;
			end
			S_CLEAR: begin
				cmd.cnt_clr = 1'b1;
				cmd.st_load = 1'b1;
				cmd.st_code = ST_CLEARED;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/top_n_rssi_sorted_table.sv -----
// Sorted table of the strongest access-point readings, strongest first.
// Input stream: one word per command. tuser carries the mode (offer a
// reading, read the entry at read_index, clear the table; the unused mode
// code reads). tdata carries the reading and the read index.
// Output stream: exactly one word per input word, in order. tuser carries
// the status code, tdata the entry count after the command, the read-valid
// flag and the fields of the read entry (zero unless a read hit).
// Timing: a read or clear passes through its own state and the completion
// state before it reaches the output register. An offer walks the table with
// one shared read port: the duplicate search, together with the removal shift
// of a stronger duplicate, then a check, a sorted placement and completion;
// an equal or weaker duplicate goes from the search straight to completion,
// and a full table whose last entry is at least as strong skips placement.
// The block returns to idle before the next word can be accepted.
// The next word is accepted as soon as the previous one has been handed to
// the output register, even if the receiver has not taken it yet; a stalled
// receiver holds the block at completion of the following word.
// Reset empties the table and the output register; the stored entries need
// no clearing since only positions below the entry count are ever used.
module top_n_rssi_sorted_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] mode
	input  logic [1:0]  s_axis_tuser,
	// [47:0] ap_bssid, [55:48] ap_rssi, [63:56] ap_channel, [67:64] ap_auth,
	// [68] ap_is_current, [72:69] read_index, [79:73] zero
	input  logic [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] status
	output logic [2:0]  m_axis_tuser,
	// [4:0] entry_count, [5] read_valid, [53:6] out_bssid, [61:54] out_rssi,
	// [69:62] out_channel, [73:70] out_auth, [74] out_is_current, [79:75] zero
	output logic [79:0] m_axis_tdata
);
	import rsst_pkg::*;

	cmd_t    cmd;
	sts_t    sts;
	item_t   item;
	result_t res;

	// Unpack the incoming word into the item fields.
	assign item.ent.bssid      = s_axis_tdata[47:0];
	assign item.ent.rssi       = s_axis_tdata[55:48];
	assign item.ent.channel    = s_axis_tdata[63:56];
	assign item.ent.auth       = s_axis_tdata[67:64];
	assign item.ent.is_current = s_axis_tdata[68];
	assign item.read_index     = s_axis_tdata[72:69];

	rsst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_mode   (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rsst_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.sts    (sts),
		.res    (res)
	);

	// Pack the result word.
	assign m_axis_tuser        = res.status;
	assign m_axis_tdata[4:0]   = res.entry_count;
	assign m_axis_tdata[5]     = res.read_valid;
	assign m_axis_tdata[53:6]  = res.ent.bssid;
	assign m_axis_tdata[61:54] = res.ent.rssi;
	assign m_axis_tdata[69:62] = res.ent.channel;
	assign m_axis_tdata[73:70] = res.ent.auth;
	assign m_axis_tdata[74]    = res.ent.is_current;
	assign m_axis_tdata[79:75] = '0;

endmodule
